/* design/apc_pkg.sv */
// Shared types, codes and constants of the actuator position controller.
`timescale 1ns / 1ps

package apc_pkg;

    // Width of the internal pulse counter (two's complement, wraps).
    localparam int POS_W = 17;

    // Field widths of the request and response channels.
    localparam int CMD_W     = 2;
    localparam int DEPTH_W   = 17;
    localparam int DUTY_W    = 10;
    localparam int OUTPOS_W  = 17;
    localparam int STEPS_W   = 16;
    localparam int SPM_W     = 10;
    localparam int BAND_W    = 10;
    localparam int DEB_W     = 16;
    localparam int STALL_W   = 20;

    // Configuration channel.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_MM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_BAND      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_WINDOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SPEED    = 3'd5;

    // Register values after reset.
    localparam logic [SPM_W-1:0]   RST_STEPS_PER_MM = 10'd155;
    localparam logic [BAND_W-1:0]  RST_STOP_BAND    = 10'd66;
    localparam logic [STEPS_W-1:0] RST_MAX_STEPS    = 16'd21800;
    localparam logic [DEB_W-1:0]   RST_DEBOUNCE     = 16'd10;
    localparam logic [STALL_W-1:0] RST_STALL_WINDOW = 20'd50000;
    localparam logic [DUTY_W-1:0]  RST_DRIVE_SPEED  = 10'd1023;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GO   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_HOME = 2'd3;

    // Direction codes.
    localparam logic [1:0] DIR_STOP    = 2'd0;
    localparam logic [1:0] DIR_EXTEND  = 2'd1;
    localparam logic [1:0] DIR_RETRACT = 2'd3;

    // Depth to steps conversion: floor(depth * steps_per_mm / 100).
    // The product is first divided by 4 with a shift, then by 25 through a
    // reciprocal multiply that is low by at most one, then corrected.
    localparam int PROD_W      = DEPTH_W + SPM_W;
    localparam int QUART_W     = PROD_W - 2;
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 30;
    localparam int QUO_W       = QUART_W + RECIP_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_25 = 26'd42949672;
    localparam logic [QUART_W-1:0] DIV_25   = 25'd25;

    // Command and sensor flag that travel alongside the target pipeline.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             sensor_pulse;
    } t_tick;

endpackage

/* design/apc_req_if.sv */
// Request channel carrying one microsecond tick.
`timescale 1ns / 1ps

interface apc_req_if;
    import apc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic               sensor_pulse;
    logic [DEPTH_W-1:0] target_depth;

    modport source (output valid, output cmd, output sensor_pulse, output target_depth,
                    input ready);
    modport sink   (input valid, input cmd, input sensor_pulse, input target_depth,
                    output ready);
endinterface

/* design/apc_rsp_if.sv */
// Response channel carrying drive duties, position and status of one tick.
`timescale 1ns / 1ps

interface apc_rsp_if;
    import apc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [DUTY_W-1:0]          right_drive;
    logic [DUTY_W-1:0]          left_drive;
    logic signed [OUTPOS_W-1:0] position;
    logic                       busy_moving;
    logic                       busy_homing;
    logic                       arrived;

    modport source (output valid, output right_drive, output left_drive, output position,
                    output busy_moving, output busy_homing, output arrived,
                    input ready);
    modport sink   (input valid, input right_drive, input left_drive, input position,
                    input busy_moving, input busy_homing, input arrived,
                    output ready);
endinterface

/* design/apc_cfg_if.sv */
// Configuration write channel.
`timescale 1ns / 1ps

interface apc_cfg_if;
    import apc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/apc_target.sv */
// Three-stage pipeline turning a depth into a clamped target step count.
`timescale 1ns / 1ps

module apc_target (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  apc_pkg::t_tick          i_tick,
    input  logic [apc_pkg::DEPTH_W-1:0] i_depth,
    input  logic [apc_pkg::SPM_W-1:0]   i_steps_per_mm,
    input  logic [apc_pkg::STEPS_W-1:0] i_max_steps,
    output logic                    o_valid,
    output apc_pkg::t_tick          o_tick,
    output logic [apc_pkg::STEPS_W-1:0] o_target
);
    import apc_pkg::*;

    logic                r_s1_valid;
    t_tick               r_s1_tick;
    logic [PROD_W-1:0]   r_s1_prod;

    logic                r_s2_valid;
    t_tick               r_s2_tick;
    logic [QUART_W-1:0]  r_s2_quart;
    logic [QUO_W-1:0]    r_s2_quo;

    logic                r_s3_valid;
    t_tick               r_s3_tick;
    logic [STEPS_W-1:0]  r_s3_target;

    logic [QUART_W+RECIP_W-1:0] w_recip_prod;
    logic [QUART_W-1:0]         w_quo_x25;
    logic [QUART_W-1:0]         w_rem;
    logic [QUO_W-1:0]           w_quo;

    // Stage 2: product / 4 times the reciprocal of 25, low by at most one.
    assign w_recip_prod = (QUART_W+RECIP_W)'(r_s1_prod[PROD_W-1:2])
                          * (QUART_W+RECIP_W)'(RECIP_25);

    // Stage 3: remainder check corrects the quotient, then the clamp.
    assign w_quo_x25 = ({QUART_W{1'b0}} | (QUART_W'(r_s2_quo) << 4))
                       + (QUART_W'(r_s2_quo) << 3) + QUART_W'(r_s2_quo);
    assign w_rem     = r_s2_quart - w_quo_x25;
    assign w_quo     = (w_rem >= DIV_25) ? r_s2_quo + QUO_W'(1) : r_s2_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_tick   <= i_tick;
            r_s1_prod   <= PROD_W'(i_depth) * PROD_W'(i_steps_per_mm);
            r_s2_tick   <= r_s1_tick;
            r_s2_quart  <= r_s1_prod[PROD_W-1:2];
            r_s2_quo    <= w_recip_prod[QUART_W+RECIP_W-1:RECIP_SHIFT];
            r_s3_tick   <= r_s2_tick;
            r_s3_target <= (w_quo > QUO_W'(i_max_steps)) ? i_max_steps : w_quo[STEPS_W-1:0];
        end
    end

    assign o_valid  = r_s3_valid;
    assign o_tick   = r_s3_tick;
    assign o_target = r_s3_target;

endmodule

/* design/actuator_position_controller_core.sv */
// Top level of the actuator position controller: registers, motion state and result stage.
`timescale 1ns / 1ps

// The block takes one request per microsecond tick on i_req: a command (tick, go to
// target, stop, home), a flag for a debounced optical sensor edge and a target depth
// in hundredths of a millimeter. For every request it returns exactly one response
// on o_rsp with the extend and retract drive duties, the signed pulse position, the
// moving and homing flags and a one-tick arrived flag.
// Registers are written on i_cfg, which is always ready; writes are meant to happen
// only while no request is in flight.
// The accepting edge loads the first of four register stages: three stages turn the
// depth into a clamped step target (multiply, reciprocal divide by 100, correction
// and clamp), and the fourth applies the tick to the motion state and loads the
// response register. Throughput is one request per cycle unless the receiver stalls;
// the motion state is fed back from its own registers through combinational logic.
// Synchronous active-low reset clears the pipeline, the motion state and restores
// the register defaults. When the receiver stalls, the whole pipeline holds and
// i_req.ready drops in the same cycle, so no response is lost.
module actuator_position_controller_core (
    input  logic i_clk,
    input  logic i_rst_n,
    apc_req_if.sink   i_req,
    apc_rsp_if.source o_rsp,
    apc_cfg_if.sink   i_cfg
);
    import apc_pkg::*;

    localparam int CMP_W = 34;

    // Configuration registers.
    logic [SPM_W-1:0]   r_steps_per_mm;
    logic [BAND_W-1:0]  r_stop_band;
    logic [STEPS_W-1:0] r_max_steps;
    logic [DEB_W-1:0]   r_debounce;
    logic [STALL_W-1:0] r_stall_window;
    logic [DUTY_W-1:0]  r_drive_speed;

    // Motion state.
    logic [POS_W-1:0]   r_count,  n_count;
    logic [1:0]         r_dir,    n_dir;
    logic               r_moving, n_moving;
    logic               r_homing, n_homing;
    logic [DEB_W-1:0]   r_tsp,    n_tsp;
    logic [STALL_W-1:0] r_stall,  n_stall;
    logic [POS_W-1:0]   r_wsc,    n_wsc;
    logic [STEPS_W-1:0] r_target, n_target;
    logic               n_arrived;
    logic               n_driving;

    // Response register.
    logic                       r_out_valid;
    logic [DUTY_W-1:0]          r_right, n_right;
    logic [DUTY_W-1:0]          r_left,  n_left;
    logic signed [OUTPOS_W-1:0] r_pos,   n_pos;
    logic                       r_out_moving;
    logic                       r_out_homing;
    logic                       r_out_arrived;

    logic               w_en;
    logic               w_t_valid;
    t_tick              w_t_tick;
    logic [STEPS_W-1:0] w_t_target;
    t_tick              w_in_tick;

    logic [DEB_W-1:0]        w_tsp_inc;
    logic                    w_counted;
    logic [POS_W-1:0]        w_count_pc;
    logic [STEPS_W-1:0]      w_tgt_sel;
    logic signed [CMP_W-1:0] w_pos_s;
    logic signed [CMP_W-1:0] w_tgt_s;
    logic signed [CMP_W-1:0] w_diff;
    logic [CMP_W-1:0]        w_dist;
    logic [STALL_W-1:0]      w_stall_inc;
    logic [32:0]             w_pos_ext;

    // The pipeline moves whenever the response register is empty or being taken.
    assign w_en        = !r_out_valid || o_rsp.ready;
    assign i_req.ready = w_en;
    assign i_cfg.ready = 1'b1;

    assign w_in_tick.cmd          = i_req.cmd;
    assign w_in_tick.sensor_pulse = i_req.sensor_pulse;

    apc_target u_target (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_req.valid),
        .i_tick         (w_in_tick),
        .i_depth        (i_req.target_depth),
        .i_steps_per_mm (r_steps_per_mm),
        .i_max_steps    (r_max_steps),
        .o_valid        (w_t_valid),
        .o_tick         (w_t_tick),
        .o_target       (w_t_target)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps_per_mm <= RST_STEPS_PER_MM;
            r_stop_band    <= RST_STOP_BAND;
            r_max_steps    <= RST_MAX_STEPS;
            r_debounce     <= RST_DEBOUNCE;
            r_stall_window <= RST_STALL_WINDOW;
            r_drive_speed  <= RST_DRIVE_SPEED;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_STEPS_PER_MM:   r_steps_per_mm <= i_cfg.data[SPM_W-1:0];
                CFG_STOP_BAND:      r_stop_band    <= i_cfg.data[BAND_W-1:0];
                CFG_MAX_STEPS:      r_max_steps    <= i_cfg.data[STEPS_W-1:0];
                CFG_DEBOUNCE_TICKS: r_debounce     <= i_cfg.data[DEB_W-1:0];
                CFG_STALL_WINDOW:   r_stall_window <= i_cfg.data[STALL_W-1:0];
                CFG_DRIVE_SPEED:    r_drive_speed  <= i_cfg.data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // Debounced pulse counting uses the direction held before this tick.
    assign w_tsp_inc  = (r_tsp != '1) ? r_tsp + DEB_W'(1) : r_tsp;
    assign w_counted  = w_t_tick.sensor_pulse && (w_tsp_inc > r_debounce);
    always_comb begin
        w_count_pc = r_count;
        if (w_counted && r_dir == DIR_EXTEND) begin
            w_count_pc = r_count + POS_W'(1);
        end else if (w_counted && r_dir == DIR_RETRACT) begin
            w_count_pc = r_count - POS_W'(1);
        end
    end

    // The target that holds once this tick's command is applied.
    assign w_tgt_sel = (w_t_tick.cmd == CMD_GO) ? w_t_target : r_target;

    // Distance to the target, compared in a width that holds either sign.
    assign w_pos_s = signed'({{(CMP_W-POS_W){w_count_pc[POS_W-1]}}, w_count_pc});
    assign w_tgt_s = signed'({{(CMP_W-STEPS_W){1'b0}}, w_tgt_sel});
    assign w_diff  = w_pos_s - w_tgt_s;
    assign w_dist  = w_diff[CMP_W-1] ? unsigned'(-w_diff) : unsigned'(w_diff);

    assign w_stall_inc = (r_stall != '1) ? r_stall + STALL_W'(1) : r_stall;

    always_comb begin
        n_tsp     = w_counted ? '0 : w_tsp_inc;
        n_count   = w_count_pc;
        n_dir     = r_dir;
        n_moving  = r_moving;
        n_homing  = r_homing;
        n_stall   = r_stall;
        n_wsc     = r_wsc;
        n_target  = r_target;
        n_arrived = 1'b0;
        n_driving = 1'b0;

        case (w_t_tick.cmd)
            CMD_GO: begin
                n_target = w_t_target;
                n_moving = 1'b1;
                n_homing = 1'b0;
            end
            CMD_STOP: begin
                n_moving = 1'b0;
                n_homing = 1'b0;
            end
            CMD_HOME: begin
                n_moving = 1'b0;
                n_homing = 1'b1;
                n_dir    = DIR_RETRACT;
                n_stall  = '0;
                n_wsc    = w_count_pc;
            end
            default: ;
        endcase

        if (n_moving) begin
            if (w_dist > CMP_W'(r_stop_band)) begin
                n_dir     = (w_tgt_s < w_pos_s) ? DIR_RETRACT : DIR_EXTEND;
                n_driving = 1'b1;
            end else begin
                n_moving  = 1'b0;
                n_arrived = 1'b1;
            end
        end else if (n_homing) begin
            n_stall   = (n_stall != '1) ? n_stall + STALL_W'(1) : n_stall;
            n_dir     = DIR_RETRACT;
            n_driving = 1'b1;
            if (n_stall >= r_stall_window) begin
                if (w_count_pc == n_wsc) begin
                    n_count   = '0;
                    n_homing  = 1'b0;
                    n_arrived = 1'b1;
                    n_driving = 1'b0;
                end else begin
                    n_wsc   = w_count_pc;
                    n_stall = '0;
                end
            end
        end
    end

    // Sign-extend or truncate the counter to the response width.
    assign w_pos_ext = {{(33-POS_W){n_count[POS_W-1]}}, n_count};
    assign n_pos     = signed'(w_pos_ext[OUTPOS_W-1:0]);
    assign n_right   = (n_driving && n_dir == DIR_EXTEND)  ? r_drive_speed : '0;
    assign n_left    = (n_driving && n_dir == DIR_RETRACT) ? r_drive_speed : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dir       <= DIR_STOP;
            r_moving    <= 1'b0;
            r_homing    <= 1'b0;
            r_tsp       <= '1;
            r_stall     <= '0;
            r_wsc       <= '0;
            r_target    <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_t_valid;
            if (w_t_valid) begin
                r_count  <= n_count;
                r_dir    <= n_dir;
                r_moving <= n_moving;
                r_homing <= n_homing;
                r_tsp    <= n_tsp;
                r_stall  <= n_stall;
                r_wsc    <= n_wsc;
                r_target <= n_target;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_t_valid) begin
            r_right       <= n_right;
            r_left        <= n_left;
            r_pos         <= n_pos;
            r_out_moving  <= n_moving;
            r_out_homing  <= n_homing;
            r_out_arrived <= n_arrived;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.right_drive = r_right;
    assign o_rsp.left_drive  = r_left;
    assign o_rsp.position    = r_pos;
    assign o_rsp.busy_moving = r_out_moving;
    assign o_rsp.busy_homing = r_out_homing;
    assign o_rsp.arrived     = r_out_arrived;

    // A move and homing are never active together.
    a_not_both_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_moving && r_homing))
        else $error("move and homing active together");

    // Homing always drives the retract side.
    a_homing_retracts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_homing |-> (r_dir == DIR_RETRACT))
        else $error("homing without retract direction");

    // Only one drive side is ever active in a response.
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_right == '0 || r_left == '0))
        else $error("both drive sides active");

    // An arrival ends all motion on the same tick.
    a_arrive_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_arrived) |-> (!r_out_moving && !r_out_homing
                                            && r_right == '0 && r_left == '0))
        else $error("arrival while still driving");

    // A stalled response holds the motion state.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> ($stable(r_count) && $stable(r_dir)))
        else $error("motion state changed during a stall");

endmodule
